FILE: sv/imhu_pkg.sv
package imhu_pkg;

   localparam int RXN_W  = 8;
   localparam int TIME_W = 32;
   localparam int CFG_W  = 9;

   localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

   // datapath operations, one per cycle
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NONE    = 4'd0;
   localparam logic [OP_W-1:0] OP_CLEAR   = 4'd1;
   localparam logic [OP_W-1:0] OP_ACCEPT  = 4'd2;
   localparam logic [OP_W-1:0] OP_LOCATE  = 4'd3;
   localparam logic [OP_W-1:0] OP_UP_READ = 4'd4;
   localparam logic [OP_W-1:0] OP_UP_MOVE = 4'd5;
   localparam logic [OP_W-1:0] OP_DN_READ = 4'd6;
   localparam logic [OP_W-1:0] OP_DN_MOVE = 4'd7;
   localparam logic [OP_W-1:0] OP_FINISH  = 4'd8;
   localparam logic [OP_W-1:0] OP_RESULT  = 4'd9;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } cmd_type;

   typedef struct packed {
      logic clear_last;   // rebuild pass at last slot
      logic in_range;     // offered reaction is inside the heap
      logic at_root;      // located slot is the root
      logic parent_root;  // parent of current slot is the root
      logic up_move;      // key smaller than parent
      logic dn_leaf;      // current slot has no children
      logic dn_move;      // key larger than smaller child
      logic rsp_free;     // output register can take a result
   } status_type;

endpackage

FILE: sv/imhu_ctrl.sv
module imhu_ctrl
   import imhu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       req_tvalid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_LOCATE = 4'd2;
   localparam logic [3:0] S_UP_RD  = 4'd3;
   localparam logic [3:0] S_UP_CMP = 4'd4;
   localparam logic [3:0] S_DN_RD  = 4'd5;
   localparam logic [3:0] S_DN_CMP = 4'd6;
   localparam logic [3:0] S_FINISH = 4'd7;
   localparam logic [3:0] S_OUT    = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       moved_ff, moved_in;

   assign req_ready = (state_ff == S_IDLE) && !csr_wr_en;

   always_comb begin
      state_in = state_ff;
      moved_in = moved_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         S_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid && !csr_wr_en) begin
               cmd.op   = OP_ACCEPT;
               state_in = status.in_range ? S_LOCATE : S_OUT;
            end
         end
         S_LOCATE: begin
            cmd.op   = OP_LOCATE;
            moved_in = 1'b0;
            state_in = status.at_root ? S_DN_RD : S_UP_RD;
         end
         S_UP_RD: begin
            cmd.op   = OP_UP_READ;
            state_in = S_UP_CMP;
         end
         S_UP_CMP: begin
            if (status.up_move) begin
               cmd.op   = OP_UP_MOVE;
               moved_in = 1'b1;
               state_in = status.parent_root ? S_FINISH : S_UP_RD;
            end else begin
               // first compare failing sends the entry toward the leaves
               state_in = moved_ff ? S_FINISH : S_DN_RD;
            end
         end
         S_DN_RD: begin
            cmd.op   = OP_DN_READ;
            state_in = status.dn_leaf ? S_FINISH : S_DN_CMP;
         end
         S_DN_CMP: begin
            if (status.dn_move) begin
               cmd.op   = OP_DN_MOVE;
               state_in = S_DN_RD;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.op   = OP_FINISH;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (status.rsp_free) begin
               cmd.op   = OP_RESULT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
      // a register write rebuilds the heap
      if (csr_wr_en) state_in = S_CLEAR;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         moved_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         moved_ff <= moved_in;
      end
   end

endmodule

FILE: sv/imhu_datapath.sv
module imhu_datapath
   import imhu_pkg::*;
#(
   parameter int MAX_ENTRIES = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic              csr_wr_en,
   input  logic [CFG_W-1:0]  csr_wr_data,
   input  logic [RXN_W-1:0]  req_reaction_id,
   input  logic [TIME_W-1:0] req_new_time,
   input  logic              rsp_tready,
   output logic              rsp_tvalid,
   output logic [RXN_W-1:0]  rsp_min_reaction,
   output logic [TIME_W-1:0] rsp_min_time
);

   localparam int SW = $clog2(MAX_ENTRIES);
   localparam int NW = $clog2(MAX_ENTRIES + 1);
   localparam int CW = (NW > CFG_W) ? NW : CFG_W;
   localparam int LW = CW + 1;

   // heap storage: key and reaction per slot, slot per reaction
   logic [TIME_W-1:0] time_mem [MAX_ENTRIES];
   logic [SW-1:0]     rxn_mem  [MAX_ENTRIES];
   logic [SW-1:0]     map_mem  [MAX_ENTRIES];

   logic [CFG_W-1:0]  active_ff;
   logic [SW-1:0]     clr_cnt_ff;
   logic [SW-1:0]     map_rd_ff;
   logic [TIME_W-1:0] rd_a_time_ff, rd_b_time_ff;
   logic [SW-1:0]     rd_a_rxn_ff, rd_b_rxn_ff;
   logic [TIME_W-1:0] cur_time_ff;
   logic [SW-1:0]     cur_rxn_ff;
   logic [SW-1:0]     cur_slot_ff;
   logic [TIME_W-1:0] root_time_ff;
   logic [SW-1:0]     root_rxn_ff;
   logic              rsp_valid_ff;
   logic [TIME_W-1:0] rsp_time_ff;
   logic [RXN_W-1:0]  rsp_rxn_ff;

   logic [CW-1:0]       cfg_ext, n_max, n_cur;
   logic [SW+RXN_W-1:0] rid_wide, root_wide;
   logic [SW-1:0]       rid_idx, par_addr, rd_a_addr, rd_b_addr;
   logic [LW-1:0]       left_addr, right_addr, n_wide;
   logic                pick_right;
   logic [TIME_W-1:0]   pick_time;
   logic [SW-1:0]       pick_rxn, pick_slot;

   logic              heap_we, map_we;
   logic [SW-1:0]     heap_waddr, map_waddr, map_wdata;
   logic [TIME_W-1:0] time_wdata;
   logic [SW-1:0]     rxn_wdata;

   // heap size, clamped to 1..MAX_ENTRIES
   assign cfg_ext = CW'(active_ff);
   assign n_max   = CW'(MAX_ENTRIES);
   always_comb begin
      if (cfg_ext == '0)         n_cur = CW'(1);
      else if (cfg_ext > n_max)  n_cur = n_max;
      else                       n_cur = cfg_ext;
   end

   assign rid_wide = {{SW{1'b0}}, req_reaction_id};
   assign rid_idx  = rid_wide[SW-1:0];

   assign par_addr   = (cur_slot_ff - SW'(1)) >> 1;
   assign left_addr  = (LW'(cur_slot_ff) << 1) + LW'(1);
   assign right_addr = left_addr + LW'(1);
   assign n_wide     = LW'(n_cur);

   // smaller child, left on a tie
   assign pick_right = (right_addr < n_wide) && (rd_b_time_ff < rd_a_time_ff);
   assign pick_time  = pick_right ? rd_b_time_ff : rd_a_time_ff;
   assign pick_rxn   = pick_right ? rd_b_rxn_ff : rd_a_rxn_ff;
   assign pick_slot  = pick_right ? right_addr[SW-1:0] : left_addr[SW-1:0];

   assign rd_a_addr = (cmd.op == OP_UP_READ) ? par_addr : left_addr[SW-1:0];
   assign rd_b_addr = right_addr[SW-1:0];

   always_comb begin
      heap_we    = 1'b0;
      heap_waddr = cur_slot_ff;
      time_wdata = cur_time_ff;
      rxn_wdata  = cur_rxn_ff;
      map_we     = 1'b0;
      map_waddr  = cur_rxn_ff;
      map_wdata  = cur_slot_ff;
      case (cmd.op)
         OP_CLEAR: begin
            heap_we    = 1'b1;
            heap_waddr = clr_cnt_ff;
            time_wdata = '0;
            rxn_wdata  = clr_cnt_ff;
            map_we     = 1'b1;
            map_waddr  = clr_cnt_ff;
            map_wdata  = clr_cnt_ff;
         end
         OP_UP_MOVE: begin
            // parent drops into the hole
            heap_we    = 1'b1;
            time_wdata = rd_a_time_ff;
            rxn_wdata  = rd_a_rxn_ff;
            map_we     = 1'b1;
            map_waddr  = rd_a_rxn_ff;
         end
         OP_DN_MOVE: begin
            heap_we    = 1'b1;
            time_wdata = pick_time;
            rxn_wdata  = pick_rxn;
            map_we     = 1'b1;
            map_waddr  = pick_rxn;
         end
         OP_FINISH: begin
            heap_we = 1'b1;
            map_we  = 1'b1;
         end
         default: begin
            heap_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (heap_we) begin
         time_mem[heap_waddr] <= time_wdata;
         rxn_mem[heap_waddr]  <= rxn_wdata;
      end
      if (map_we) map_mem[map_waddr] <= map_wdata;
      rd_a_time_ff <= time_mem[rd_a_addr];
      rd_a_rxn_ff  <= rxn_mem[rd_a_addr];
      rd_b_time_ff <= time_mem[rd_b_addr];
      rd_b_rxn_ff  <= rxn_mem[rd_b_addr];
      map_rd_ff    <= map_mem[rid_idx];
   end

   // working entry, root copy and result register
   always_ff @(posedge clock) begin
      if (cmd.op == OP_ACCEPT) begin
         cur_time_ff <= req_new_time;
         cur_rxn_ff  <= rid_idx;
      end
      case (cmd.op)
         OP_LOCATE:  cur_slot_ff <= map_rd_ff;
         OP_UP_MOVE: cur_slot_ff <= par_addr;
         OP_DN_MOVE: cur_slot_ff <= pick_slot;
         default:    cur_slot_ff <= cur_slot_ff;
      endcase
      if (heap_we && heap_waddr == '0) begin
         root_time_ff <= time_wdata;
         root_rxn_ff  <= rxn_wdata;
      end
      if (cmd.op == OP_RESULT) begin
         rsp_time_ff <= root_time_ff;
         rsp_rxn_ff  <= root_wide[RXN_W-1:0];
      end
   end

   assign root_wide = {{RXN_W{1'b0}}, root_rxn_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= CFG_RESET;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) active_ff <= csr_wr_data;
         clr_cnt_ff <= (cmd.op == OP_CLEAR) ? clr_cnt_ff + SW'(1) : '0;
         if (cmd.op == OP_RESULT)  rsp_valid_ff <= 1'b1;
         else if (rsp_tready)      rsp_valid_ff <= 1'b0;
      end
   end

   assign status.clear_last  = (clr_cnt_ff == SW'(MAX_ENTRIES - 1));
   assign status.in_range    = (CW'(req_reaction_id) < n_cur);
   assign status.at_root     = (map_rd_ff == '0);
   assign status.parent_root = (par_addr == '0);
   assign status.up_move     = (cur_time_ff < rd_a_time_ff);
   assign status.dn_leaf     = (left_addr >= n_wide);
   assign status.dn_move     = (cur_time_ff > pick_time);
   assign status.rsp_free    = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_min_time     = rsp_time_ff;
   assign rsp_min_reaction = rsp_rxn_ff;

endmodule

FILE: sv/indexed_min_heap_update_top.sv
// Channel   Direction  tdata (low bit first)                   Handshake
// req       in         reaction_id[7:0], new_time[39:8]        req_tvalid / req_tready
// rsp       out        min_reaction[7:0], min_time[39:8]       rsp_tvalid / rsp_tready
// csr       in         active_entries[8:0]                     csr_wr_en
//
// Steps: accept, map lookup, a read and compare per level moved, a stop at a leaf or
//   a failed compare, one more read and compare when an entry cannot rise and sinks
//   instead, final write, result load; out of range: accept, then result load.
// Reset (synchronous) and every csr write lead into a rebuild pass over the slot
//   memories; req_tready stays low meanwhile.
// One request in flight; the next is taken while a result waits on rsp.
module indexed_min_heap_update_top
   import imhu_pkg::*;
#(
   parameter int MAX_ENTRIES = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   // request: reaction_id, new_time
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [RXN_W+TIME_W-1:0] req_tdata,
   // result: min_reaction, min_time
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RXN_W+TIME_W-1:0] rsp_tdata,
   // active_entries
   input  logic                    csr_wr_en,
   input  logic [CFG_W-1:0]        csr_wr_data
);

   cmd_type           cmd;
   status_type        status;
   logic [RXN_W-1:0]  min_reaction;
   logic [TIME_W-1:0] min_time;

   imhu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .req_tvalid (req_tvalid),
      .req_ready  (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   imhu_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_reaction_id  (req_tdata[RXN_W-1:0]),
      .req_new_time     (req_tdata[RXN_W+TIME_W-1:RXN_W]),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_min_reaction (min_reaction),
      .rsp_min_time     (min_time)
   );

   assign rsp_tdata = {min_time, min_reaction};

   // rebuild pass holds off requests right after reset
   a_reset_blocks_req: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request taken during rebuild after reset");

   // a csr write always puts the controller into the rebuild
   a_csr_rebuild: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> !req_tready)
      else $error("request taken right after csr write");

   // a result never overwrites one not yet taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_RESULT) |-> (!rsp_tvalid || rsp_tready))
      else $error("result loaded over pending result");

   // a loaded result is presented next cycle
   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_RESULT) |=> rsp_tvalid)
      else $error("loaded result not presented");

endmodule
